@@ sv/tbt_pkg.sv @@
package tbt_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 7;

    // neighbour count limits for a removable pixel
    localparam int NB_MIN = 2;
    localparam int NB_MAX = 6;

    // subiteration counter
    localparam int               COUNT_W   = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    // reset frame size
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(MAX_HEIGHT);

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_THIN  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef logic [MAX_WIDTH-1:0] row_bits_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic       pixel_in;
    } in_word_t;

    typedef struct packed {
        logic               pixel_out;
        logic [COUNT_W-1:0] pass_count;
    } out_word_t;

endpackage

@@ sv/binary_image_thinning_core.sv @@
// channel | direction | handshake                  | word
// in      | input     | in_valid / in_stall        | in_word (cmd, row, col, pixel_in)
// out     | output    | out_valid / out_stall      | out_word (pixel_out, pass_count)
// cfg     | input     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// pixel write and read do a row read, then write-back or bit select
// thinning runs subiterations of first, prime, the row state for each row of the frame
// height in use, and end, one memory row per cycle; an empty frame goes from first to end
// reset (rst_n, async low) clears control state and sets the frame to 64 x 64;
// the image memory is not cleared
// a new word is taken only in idle, when the output register is empty or drains
module binary_image_thinning_core
    import tbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ACCESS = 6'b000010,
        S_FIRST  = 6'b000100,
        S_PRIME  = 6'b001000,
        S_ROW    = 6'b010000,
        S_END    = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    in_word_t           item_reg, item_next;
    logic [DIM_W-1:0]   fw_reg, fh_reg;
    logic [DIM_W-1:0]   w_eff, h_eff;
    row_bits_t          prev_reg, prev_next;
    row_bits_t          cur_reg, cur_next;
    logic [ROW_W-1:0]   r_reg, r_next;
    logic               phase_reg, phase_next;
    logic               any_del_reg, any_del_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    row_bits_t          col_mask;
    row_bits_t          below_row;
    row_bits_t          marks;
    logic [DIM_W-1:0]   r_plus1;
    logic               in_frame;
    logic               in_acc;

    logic               mem_we;
    logic [ROW_W-1:0]   mem_waddr;
    row_bits_t          mem_wdata;
    logic [ROW_W-1:0]   mem_raddr;
    row_bits_t          mem_rdata;

    // image memory, one frame row per entry
    tbt_ram #(
        .WIDTH(MAX_WIDTH),
        .DEPTH(MAX_HEIGHT)
    ) u_image (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // per-row removal marks on the snapshot window
    tbt_row_judge u_judge (
        .above (prev_reg & col_mask),
        .center(cur_reg & col_mask),
        .below (below_row & col_mask),
        .phase (phase_reg),
        .marks (marks)
    );

    // frame size in use, clamped to the memory
    assign w_eff = (fw_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_reg;
    assign h_eff = (fh_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_reg;

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            col_mask[c] = (DIM_W'(c) < w_eff);
        end
    end

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign in_frame  = ({1'b0, item_reg.row} < h_eff) && ({1'b0, item_reg.col} < w_eff);
    assign r_plus1   = {1'b0, r_reg} + DIM_W'(1);
    assign below_row = (r_plus1 < h_eff) ? mem_rdata : '0;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        r_next         = r_reg;
        phase_next     = phase_reg;
        any_del_next   = any_del_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        mem_we         = 1'b0;
        mem_waddr      = r_reg;
        mem_wdata      = cur_reg & ~marks;
        mem_raddr      = in_word.row;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    item_next = in_word;
                    if (in_word.cmd == CMD_THIN)
                    begin
                        count_next = '0;
                        phase_next = 1'b0;
                        state_next = S_FIRST;
                    end
                    else
                    begin
                        state_next = S_ACCESS;
                    end
                end
            end

            // row data is back: write-back or bit select
            S_ACCESS:
            begin
                out_word_next  = '0;
                out_valid_next = 1'b1;
                mem_waddr      = item_reg.row;
                mem_wdata      = mem_rdata;
                mem_wdata[item_reg.col] = item_reg.pixel_in;
                case (item_reg.cmd)
                    CMD_WRITE: mem_we = in_frame;
                    CMD_READ:  out_word_next.pixel_out = in_frame && mem_rdata[item_reg.col];
                    default:   mem_we = 1'b0;
                endcase
                state_next = S_IDLE;
            end

            S_FIRST:
            begin
                mem_raddr    = '0;
                any_del_next = 1'b0;
                state_next   = (h_eff == '0) ? S_END : S_PRIME;
            end

            S_PRIME:
            begin
                prev_next  = '0;
                cur_next   = mem_rdata;
                r_next     = '0;
                mem_raddr  = ROW_W'(1);
                state_next = S_ROW;
            end

            // judge row r, write it back, shift the window, fetch row r+2
            S_ROW:
            begin
                mem_we    = 1'b1;
                mem_waddr = r_reg;
                mem_wdata = cur_reg & ~marks;
                mem_raddr = r_reg + ROW_W'(2);
                if (|marks)
                begin
                    any_del_next = 1'b1;
                end
                prev_next = cur_reg;
                cur_next  = below_row;
                r_next    = r_reg + ROW_W'(1);
                if (r_plus1 == h_eff)
                begin
                    state_next = S_END;
                end
            end

            S_END:
            begin
                count_next = count_inc;
                if (any_del_reg)
                begin
                    phase_next = !phase_reg;
                    state_next = S_FIRST;
                end
                else
                begin
                    out_word_next.pixel_out  = 1'b0;
                    out_word_next.pass_count = count_inc;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            any_del_reg   <= 1'b0;
            count_reg     <= '0;
            fw_reg        <= FRAME_WIDTH_RST;
            fh_reg        <= FRAME_HEIGHT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            any_del_reg   <= any_del_next;
            count_reg     <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default:          fw_reg <= fw_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        r_reg        <= r_next;
        out_word_reg <= out_word_next;
    end

endmodule

@@ sv/tbt_ram.sv @@
module tbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/tbt_row_judge.sv @@
module tbt_row_judge
    import tbt_pkg::*;
(
    input  row_bits_t above,
    input  row_bits_t center,
    input  row_bits_t below,
    input  logic      phase,
    output row_bits_t marks
);

    // zero columns on both sides of the frame
    logic [MAX_WIDTH+1:0] up_x;
    logic [MAX_WIDTH+1:0] mid_x;
    logic [MAX_WIDTH+1:0] dn_x;

    assign up_x  = {1'b0, above, 1'b0};
    assign mid_x = {1'b0, center, 1'b0};
    assign dn_x  = {1'b0, below, 1'b0};

    // ring order p2..p9, clockwise from north
    function automatic logic judge_pixel(input logic [7:0] ring, input logic ph);
        logic [3:0] sum;
        logic [3:0] trans;
        logic       rule;
        sum   = '0;
        trans = '0;
        for (int k = 0; k < 8; k++)
        begin
            sum = sum + 4'(ring[k]);
            if (!ring[k] && ring[(k + 1) % 8])
            begin
                trans = trans + 4'd1;
            end
        end
        // p2 = ring[0], p4 = ring[2], p6 = ring[4], p8 = ring[6]
        if (!ph)
        begin
            rule = !(ring[0] && ring[2] && ring[4]) && !(ring[2] && ring[4] && ring[6]);
        end
        else
        begin
            rule = !(ring[0] && ring[2] && ring[6]) && !(ring[0] && ring[4] && ring[6]);
        end
        return (sum >= 4'(NB_MIN)) && (sum <= 4'(NB_MAX)) && (trans == 4'd1) && rule;
    endfunction

    // one lane per column, all independent
    always_comb
    begin
        logic [7:0] ring;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            ring[0] = up_x[c+1];
            ring[1] = up_x[c+2];
            ring[2] = mid_x[c+2];
            ring[3] = dn_x[c+2];
            ring[4] = dn_x[c+1];
            ring[5] = dn_x[c];
            ring[6] = mid_x[c];
            ring[7] = up_x[c];
            marks[c] = mid_x[c+1] && judge_pixel(ring, phase);
        end
    end

endmodule
